// ===== sv/pea_pkg.sv =====
package pea_pkg;

    localparam int DEF_MAX_EXTENTS = 64;

    localparam int FRAME_W  = 32;
    localparam int SUM_W    = FRAME_W + 1;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 2 * FRAME_W;
    localparam int OUT_W    = 40;
    localparam int OUT_PAD  = OUT_W - STATUS_W - FRAME_W;

    localparam logic ACT_FREE  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic               sub;
        logic [FRAME_W-1:0] a;
        logic [FRAME_W-1:0] b;
    } alu_req_t;

endpackage

// ===== sv/page_extent_allocator_best_fit.sv =====
// Channel   Direction  Handshake           Payload
// request   in         s_tvalid/s_tready   s_tuser: action; s_tdata: start_frame, page_count
// result    out        m_tvalid/m_tready   m_tdata: status, granted_frame
//
// A scanned request passes through the scan, drain, eval and decide states, and a free that
// writes the table back also through merge; the scan reads one extent entry per cycle.
// A zero count, or a free that wraps past the top frame, skips the scan.
// Reset clears the valid marks at once and leaves the extent memory as it is.
// A finished result waits in the output register while the next request is accepted; a
// further result waits until the previous one has been taken.
module page_extent_allocator_best_fit
    import pea_pkg::*;
#(
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,  // start_frame [31:0], page_count [63:32]
    input  logic             s_tuser,  // action [0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata   // status [1:0], granted_frame [33:2], zero [39:34]
);

    localparam int IDX_W = $clog2(MAX_EXTENTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_EXTENTS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_MERGE  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [FRAME_W-1:0] start_mem [MAX_EXTENTS];
    logic [FRAME_W-1:0] len_mem [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0] valid_reg;
    logic [MAX_EXTENTS-1:0] valid_next;

    logic                action_reg;
    logic [FRAME_W-1:0]  first_reg;
    logic [FRAME_W-1:0]  count_reg;
    logic [SUM_W-1:0]    end_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [FRAME_W-1:0]  acc_reg;

    logic [IDX_W-1:0]    scan_idx_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                rd_live_reg;
    logic [FRAME_W-1:0]  rd_start_reg;
    logic [FRAME_W-1:0]  rd_len_reg;

    logic                hi_found_reg;
    logic [IDX_W-1:0]    hi_idx_reg;
    logic [FRAME_W-1:0]  hi_start_reg;
    logic [FRAME_W-1:0]  hi_len_reg;
    logic                lo_found_reg;
    logic [IDX_W-1:0]    lo_idx_reg;
    logic [FRAME_W-1:0]  lo_start_reg;
    logic [FRAME_W-1:0]  lo_len_reg;
    logic                spare_found_reg;
    logic [IDX_W-1:0]    spare_idx_reg;
    logic                join_hi_reg;
    logic                join_lo_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [FRAME_W-1:0]  res_granted_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic [FRAME_W-1:0]  in_first;
    logic [FRAME_W-1:0]  in_count;
    logic                accept;
    logic                out_load;

    alu_req_t            alu_req;
    logic [SUM_W-1:0]    alu_sum;

    logic                rd_v;
    logic                hi_take;
    logic                lo_take;
    logic                spare_take;

    logic                over;
    logic                join_hi;
    logic                join_lo;
    logic                exact;
    logic [IDX_W-1:0]    slot;

    assign in_first = s_tdata[FRAME_W-1:0];
    assign in_count = s_tdata[IN_W-1:FRAME_W];
    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    pea_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    always_comb begin
        alu_req = '0;
        unique case (state_reg)
            S_IDLE: begin
                alu_req.a = in_first;
                alu_req.b = in_count;
            end
            S_EVAL: begin
                if (action_reg == ACT_FREE) begin
                    alu_req.a = lo_start_reg;
                    alu_req.b = lo_len_reg;
                end else begin
                    alu_req.sub = 1'b1;
                    alu_req.a   = hi_len_reg;
                    alu_req.b   = count_reg;
                end
            end
            S_DECIDE: begin
                if (action_reg == ACT_FREE) begin
                    alu_req.a = count_reg;
                    alu_req.b = join_hi ? hi_len_reg : '0;
                end else begin
                    alu_req.a = hi_start_reg;
                    alu_req.b = sum_reg[FRAME_W-1:0];
                end
            end
            S_MERGE: begin
                alu_req.a = acc_reg;
                alu_req.b = join_lo_reg ? lo_len_reg : '0;
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    // Scan comparison on the entry read in the previous cycle.
    always_comb begin
        rd_v       = valid_reg[rd_idx_reg];
        spare_take = rd_live_reg && !rd_v && !spare_found_reg;
        lo_take    = rd_live_reg && rd_v && (action_reg == ACT_FREE) &&
                     (rd_start_reg <= first_reg) &&
                     (!lo_found_reg || rd_start_reg > lo_start_reg);
        if (action_reg == ACT_FREE) begin
            hi_take = rd_live_reg && rd_v && (rd_start_reg >= first_reg) &&
                      (!hi_found_reg || rd_start_reg < hi_start_reg);
        end else begin
            hi_take = rd_live_reg && rd_v && (rd_len_reg >= count_reg) &&
                      (!hi_found_reg || rd_len_reg < hi_len_reg ||
                       (rd_len_reg == hi_len_reg && rd_start_reg < hi_start_reg));
        end
    end

    always_comb begin
        over    = (hi_found_reg && end_reg > {1'b0, hi_start_reg}) ||
                  (lo_found_reg && sum_reg > {1'b0, first_reg});
        join_hi = hi_found_reg && (end_reg == {1'b0, hi_start_reg});
        join_lo = lo_found_reg && (sum_reg == {1'b0, first_reg});
        exact   = (sum_reg[FRAME_W-1:0] == '0);
        if (join_hi_reg) begin
            slot = hi_idx_reg;
        end else if (join_lo_reg) begin
            slot = lo_idx_reg;
        end else begin
            slot = spare_idx_reg;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (state_reg == S_DECIDE && action_reg == ACT_ALLOC && hi_found_reg && exact) begin
            valid_next[hi_idx_reg] = 1'b0;
        end
        if (state_reg == S_MERGE) begin
            if (join_hi_reg && join_lo_reg) begin
                valid_next[lo_idx_reg] = 1'b0;
            end
            valid_next[slot] = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_count == '0 || (s_tuser == ACT_FREE && alu_sum[FRAME_W])) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_EVAL;
            S_EVAL:   state_next = S_DECIDE;
            S_DECIDE: begin
                if (action_reg == ACT_FREE && !over &&
                    (join_hi || join_lo || spare_found_reg)) begin
                    state_next = S_MERGE;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_MERGE:  state_next = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            rd_live_reg     <= 1'b0;
            hi_found_reg    <= 1'b0;
            lo_found_reg    <= 1'b0;
            spare_found_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            rd_live_reg <= (state_reg == S_SCAN);
            if (accept) begin
                hi_found_reg    <= 1'b0;
                lo_found_reg    <= 1'b0;
                spare_found_reg <= 1'b0;
            end else begin
                if (hi_take) begin
                    hi_found_reg <= 1'b1;
                end
                if (lo_take) begin
                    lo_found_reg <= 1'b1;
                end
                if (spare_take) begin
                    spare_found_reg <= 1'b1;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_start_reg <= start_mem[scan_idx_reg];
        rd_len_reg   <= len_mem[scan_idx_reg];
        rd_idx_reg   <= scan_idx_reg;
        if (state_reg == S_MERGE) begin
            start_mem[slot] <= join_lo_reg ? lo_start_reg : first_reg;
            len_mem[slot]   <= alu_sum[FRAME_W-1:0];
        end else if (state_reg == S_DECIDE && action_reg == ACT_ALLOC &&
                     hi_found_reg && !exact) begin
            len_mem[hi_idx_reg] <= sum_reg[FRAME_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg      <= s_tuser;
            first_reg       <= in_first;
            count_reg       <= in_count;
            end_reg         <= alu_sum;
            scan_idx_reg    <= '0;
            res_status_reg  <= ST_INVALID;
            res_granted_reg <= '0;
        end
        if (state_reg == S_SCAN) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (hi_take) begin
            hi_idx_reg   <= rd_idx_reg;
            hi_start_reg <= rd_start_reg;
            hi_len_reg   <= rd_len_reg;
        end
        if (lo_take) begin
            lo_idx_reg   <= rd_idx_reg;
            lo_start_reg <= rd_start_reg;
            lo_len_reg   <= rd_len_reg;
        end
        if (spare_take) begin
            spare_idx_reg <= rd_idx_reg;
        end
        if (state_reg == S_EVAL) begin
            sum_reg <= alu_sum;
        end
        if (state_reg == S_DECIDE) begin
            join_hi_reg <= join_hi;
            join_lo_reg <= join_lo;
            acc_reg     <= alu_sum[FRAME_W-1:0];
            if (action_reg == ACT_FREE) begin
                if (over) begin
                    res_status_reg <= ST_INVALID;
                end else if (!join_hi && !join_lo && !spare_found_reg) begin
                    res_status_reg <= ST_FULL;
                end else begin
                    res_status_reg <= ST_OK;
                end
            end else if (!hi_found_reg) begin
                res_status_reg <= ST_NO_FIT;
            end else begin
                res_status_reg  <= ST_OK;
                res_granted_reg <= exact ? hi_start_reg : alu_sum[FRAME_W-1:0];
            end
        end
        if (out_load) begin
            m_tdata_reg <= {{OUT_PAD{1'b0}}, res_granted_reg, res_status_reg};
        end
    end

    property p_no_grant_on_error;
        @(posedge aclk) disable iff (!aresetn)
            m_tvalid && (m_tdata[STATUS_W-1:0] != ST_OK) |->
                (m_tdata[STATUS_W+FRAME_W-1:STATUS_W] == '0);
    endproperty
    assert property (p_no_grant_on_error)
        else $error("granted frame set on a failed request");

    property p_busy_after_accept;
        @(posedge aclk) disable iff (!aresetn)
            accept |=> !s_tready;
    endproperty
    assert property (p_busy_after_accept)
        else $error("request accepted while a previous one is in progress");

    property p_merge_has_slot;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == S_MERGE) |-> (join_hi_reg || join_lo_reg || spare_found_reg);
    endproperty
    assert property (p_merge_has_slot)
        else $error("extent write without a target entry");

endmodule

// ===== sv/pea_alu.sv =====
module pea_alu
    import pea_pkg::*;
(
    input  alu_req_t         req,
    output logic [SUM_W-1:0] sum
);

    logic [SUM_W-1:0] a_ext;
    logic [SUM_W-1:0] b_ext;

    assign a_ext = {1'b0, req.a};
    assign b_ext = {1'b0, req.b};
    assign sum   = req.sub ? (a_ext - b_ext) : (a_ext + b_ext);

endmodule

// ===== tb/page_extent_allocator_best_fit_tb.sv =====
module page_extent_allocator_best_fit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pea_pkg::*;

    localparam int          NUM_RANDOM    = 1680;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = DEF_MAX_EXTENTS + 10;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  grant;
    } extent_reply_t;

    typedef struct {
        logic [FRAME_W-1:0] base;
        logic [FRAME_W-1:0] pages;
    } page_run_t;

    class extent_pool_scoreboard;
        logic [FRAME_W-1:0] ext_base [DEF_MAX_EXTENTS];
        logic [FRAME_W-1:0] ext_pages [DEF_MAX_EXTENTS];
        bit                 ext_used [DEF_MAX_EXTENTS];
        extent_reply_t      awaited[$];
        int                 mismatches;

        function logic [STATUS_W-1:0] free_pages(logic [FRAME_W-1:0] first,
                                                 logic [FRAME_W-1:0] count);
            logic [SUM_W-1:0]   stop_frame;
            logic [SUM_W-1:0]   below_top;
            logic [FRAME_W-1:0] new_base;
            logic [FRAME_W-1:0] new_pages;
            int                 above;
            int                 below;
            int                 spare;
            int                 slot;
            bit                 join_above;
            bit                 join_below;
            stop_frame = {1'b0, first} + {1'b0, count};
            if (count == '0 || stop_frame[FRAME_W]) return ST_INVALID;
            above = -1;
            below = -1;
            spare = -1;
            for (int i = 0; i < DEF_MAX_EXTENTS; i++) begin
                if (!ext_used[i]) begin
                    if (spare < 0) spare = i;
                    continue;
                end
                if (ext_base[i] >= first && (above < 0 || ext_base[i] < ext_base[above]))
                    above = i;
                if (ext_base[i] <= first && (below < 0 || ext_base[i] > ext_base[below]))
                    below = i;
            end
            if (above >= 0 && stop_frame > {1'b0, ext_base[above]}) return ST_INVALID;
            below_top = '0;
            if (below >= 0) below_top = {1'b0, ext_base[below]} + {1'b0, ext_pages[below]};
            if (below >= 0 && below_top > {1'b0, first}) return ST_INVALID;
            join_above = above >= 0 && stop_frame == {1'b0, ext_base[above]};
            join_below = below >= 0 && below_top == {1'b0, first};
            if (!join_above && !join_below && spare < 0) return ST_FULL;
            new_base  = first;
            new_pages = count;
            if (join_above) new_pages += ext_pages[above];
            if (join_below) begin
                new_pages += ext_pages[below];
                new_base = ext_base[below];
            end
            if (join_above) begin
                slot = above;
                if (join_below) ext_used[below] = 1'b0;
            end else if (join_below) begin
                slot = below;
            end else begin
                slot = spare;
            end
            ext_base[slot]  = new_base;
            ext_pages[slot] = new_pages;
            ext_used[slot]  = 1'b1;
            return ST_OK;
        endfunction

        function logic [STATUS_W-1:0] alloc_pages(logic [FRAME_W-1:0] count,
                                                  output logic [FRAME_W-1:0] grant);
            int best;
            grant = '0;
            if (count == '0) return ST_INVALID;
            best = -1;
            for (int i = 0; i < DEF_MAX_EXTENTS; i++) begin
                if (!ext_used[i] || ext_pages[i] < count) continue;
                if (best < 0 || ext_pages[i] < ext_pages[best] ||
                    (ext_pages[i] == ext_pages[best] && ext_base[i] < ext_base[best]))
                    best = i;
            end
            if (best < 0) return ST_NO_FIT;
            if (ext_pages[best] == count) begin
                grant = ext_base[best];
                ext_used[best] = 1'b0;
            end else begin
                ext_pages[best] -= count;
                grant = ext_base[best] + ext_pages[best];
            end
            return ST_OK;
        endfunction

        function void note_request(logic act, logic [FRAME_W-1:0] first,
                                   logic [FRAME_W-1:0] count, output extent_reply_t reply);
            reply.grant = '0;
            if (act == ACT_FREE) reply.status = free_pages(first, count);
            else reply.status = alloc_pages(count, reply.grant);
            awaited.push_back(reply);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            extent_reply_t      want;
            logic [STATUS_W-1:0] got_status;
            logic [FRAME_W-1:0]  got_grant;
            got_status = data[STATUS_W-1:0];
            got_grant  = data[STATUS_W+FRAME_W-1:STATUS_W];
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result with no request outstanding: status %0d frame %h",
                             got_status, got_grant);
                return;
            end
            want = awaited.pop_front();
            if (got_status !== want.status || got_grant !== want.grant) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected status %0d frame %h, got status %0d frame %h",
                             want.status, want.grant, got_status, got_grant);
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata  = '0;
    logic               s_tuser  = ACT_FREE;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;

    extent_pool_scoreboard sb = new;
    int                    tx_idle_pct = 22;
    int                    rx_idle_pct = 75;
    int unsigned           cycles = 0;
    page_run_t             held[$];
    logic [FRAME_W-1:0]    fresh_base;
    logic [FRAME_W-1:0]    fresh_ptr;

    page_extent_allocator_best_fit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    initial begin
        wait (cycles == CYCLE_LIMIT);
        $display("FAIL page_extent_allocator_best_fit");
        $finish;
    end

    task automatic send_request(input logic act, input logic [FRAME_W-1:0] first,
                                input logic [FRAME_W-1:0] count, output extent_reply_t reply);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {count, first};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(act, first, count, reply);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
    endtask

    task automatic free_fresh_run();
        page_run_t     run;
        extent_reply_t reply;
        run.base  = fresh_ptr;
        run.pages = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 512) : $urandom_range(1, 16);
        fresh_ptr = fresh_ptr + run.pages + $urandom_range(0, 3);
        send_request(ACT_FREE, run.base, run.pages, reply);
        if (reply.status != ST_OK) held.push_back(run);
    endtask

    task automatic free_held_part();
        int                 idx;
        logic [FRAME_W-1:0] off;
        logic [FRAME_W-1:0] n;
        page_run_t          run;
        extent_reply_t      reply;
        idx = $urandom_range(0, held.size() - 1);
        run = held[idx];
        off = $urandom_range(0, 1) ? '0 : FRAME_W'($urandom_range(0, run.pages - 1));
        n   = $urandom_range(0, 1) ? run.pages - off : FRAME_W'($urandom_range(1, run.pages - off));
        send_request(ACT_FREE, run.base + off, n, reply);
        if (reply.status == ST_OK) begin
            held.delete(idx);
            if (off != '0) held.push_back('{run.base, off});
            if (off + n != run.pages) held.push_back('{run.base + off + n, run.pages - off - n});
        end
    endtask

    task automatic alloc_random();
        logic [FRAME_W-1:0] count;
        extent_reply_t      reply;
        case ($urandom_range(0, 9))
            0:       count = $urandom;
            1, 2:    count = $urandom_range(9, 300);
            default: count = $urandom_range(1, 8);
        endcase
        send_request(ACT_ALLOC, $urandom, count, reply);
        if (reply.status == ST_OK) held.push_back('{reply.grant, count});
    endtask

    task automatic send_noise();
        extent_reply_t reply;
        case ($urandom_range(0, 4))
            0: send_request(ACT_FREE, $urandom, '0, reply);
            1: send_request(ACT_ALLOC, $urandom, '0, reply);
            2: send_request(ACT_FREE, $urandom, $urandom, reply);
            3: send_request(ACT_FREE, fresh_base + $urandom_range(0, fresh_ptr - fresh_base),
                            $urandom_range(1, 8), reply);
            default: send_request(ACT_FREE, 32'hFFFF_FFFF - $urandom_range(0, 15),
                                  $urandom_range(1, 32), reply);
        endcase
    endtask

    initial begin
        extent_reply_t reply;
        int            pick;
        bit            fill_mode;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(ACT_ALLOC, '0, '0, reply);
        send_request(ACT_ALLOC, 32'hFFFF_FFFF, 32'd1, reply);
        send_request(ACT_FREE, 32'd100, '0, reply);
        send_request(ACT_FREE, 32'hFFFF_FFFF, 32'd1, reply);
        send_request(ACT_FREE, 32'hFFFF_FFFE, 32'd1, reply);
        send_request(ACT_FREE, '0, 32'hFFFF_FFFF, reply);
        send_request(ACT_FREE, '0, 32'hFFFF_FFFE, reply);
        send_request(ACT_ALLOC, '0, 32'hFFFF_FFFF, reply);
        send_request(ACT_ALLOC, '0, 32'd1, reply);
        send_request(ACT_FREE, 32'd100, 32'd10, reply);
        send_request(ACT_FREE, 32'd120, 32'd10, reply);
        send_request(ACT_FREE, 32'd105, 32'd2, reply);
        send_request(ACT_FREE, 32'd95, 32'd6, reply);
        send_request(ACT_FREE, 32'd110, 32'd10, reply);
        send_request(ACT_FREE, 32'd200, 32'd30, reply);
        send_request(ACT_ALLOC, 32'h5555_AAAA, 32'd30, reply);
        send_request(ACT_ALLOC, '0, 32'd5, reply);
        send_request(ACT_FREE, 32'd225, 32'd5, reply);
        send_request(ACT_FREE, 32'd195, 32'd5, reply);
        send_request(ACT_FREE, 32'd300, 32'd3, reply);
        send_request(ACT_ALLOC, '0, 32'd3, reply);
        send_request(ACT_ALLOC, '0, 32'd40, reply);
        send_request(ACT_FREE, 32'h8000_0000, 32'h7FFF_FFFF, reply);
        drain_results();

        fresh_base = 32'h1000_0000 + ($urandom_range(0, 255) << 16);
        fresh_ptr  = fresh_base;
        for (int k = 0; k < NUM_RANDOM; k++) begin
            if (k == NUM_RANDOM / 3) begin
                tx_idle_pct = 75;
                rx_idle_pct = 22;
            end
            if (k == 2 * NUM_RANDOM / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // Alternate between windows that fragment the pool towards a full table
            // and windows that mostly allocate from it.
            fill_mode = ((k / 120) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_noise();
            end else if (pick < (fill_mode ? 70 : 35)) begin
                if (held.size() > 0 && $urandom_range(0, 1)) free_held_part();
                else free_fresh_run();
            end else begin
                alloc_random();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("PASS page_extent_allocator_best_fit");
        end else begin
            $display("FAIL page_extent_allocator_best_fit");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pea_pkg.sv
sv/pea_alu.sv
sv/page_extent_allocator_best_fit.sv
tb/page_extent_allocator_best_fit_tb.sv
